[hdl/bounded_deque_with_search_top_macros.svh]
// =============================================================================
// Assertion macros for the bounded deque with search
// Concurrent assertion shorthands used by the datapath of this block.
// =============================================================================
`ifndef BOUNDED_DEQUE_WITH_SEARCH_TOP_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define BDQS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define BDQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define BDQS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BDQS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/bdqs_pkg.sv]
// =============================================================================
// Bounded deque package
// Request codes, word types and controller/datapath interface structs.
// =============================================================================
package bdqs_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [1:0] REQ_QUERY      = 2'd2;

  // Input word.
  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] value;
  } bdqs_in_t;

  // Result word.
  typedef struct packed {
    logic       found;
    logic [4:0] count;
    logic       is_empty;
    logic       dropped;
  } bdqs_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;    // capture the accepted input word
    logic exec_push;   // apply a push (or nothing for an unused code)
    logic scan_start;  // set up a membership scan
    logic scan_step;   // advance the scan by one entry
    logic load_out;    // load the result register
  } bdqs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic scan_done;
    logic out_free;
  } bdqs_sts_t;

endpackage

[hdl/bdqs_ram.sv]
// =============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// =============================================================================
module bdqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

[hdl/bdqs_ctrl.sv]
// =============================================================================
// Deque controller
// Sequences acceptance, push execution, membership scan and result hand-off.
// =============================================================================
module bdqs_ctrl
  import bdqs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  bdqs_sts_t sts_i,
  output bdqs_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.is_query) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end else if (sts_i.out_free) begin
          cmd_o.exec_push = 1'b1;
          cmd_o.load_out  = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Input words are taken only while idle.
  assign in_stall_o = (state_q != S_IDLE);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/bdqs_dp.sv]
// =============================================================================
// Deque datapath
// Ring pointers, element count, entry storage, scan logic and result register.
// =============================================================================
`include "bounded_deque_with_search_top_macros.svh"

module bdqs_dp
  import bdqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bdqs_cmd_t cmd_i,
  output bdqs_sts_t sts_o,
  input  bdqs_in_t  in_data_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output bdqs_out_t out_data_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // Request and ring state.
  logic [1:0]    req_q;
  logic [31:0]   val_q;
  logic [IW-1:0] front_q, front_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // Scan state.
  logic [IW-1:0] rd_ptr_q;
  logic [CW-1:0] scan_k_q;
  logic          rd_pend_q;
  logic          found_q;

  // Result register.
  logic          out_valid_q;
  bdqs_out_t     out_q;

  logic          is_push, full, issue_rd, match;
  logic [IW-1:0] front_dec, back_idx, wr_addr;
  logic [SW-1:0] back_sum;
  logic          wr_en;
  logic [31:0]   rd_data;

  // Request decode and ring address arithmetic.
  assign is_push   = (req_q == REQ_PUSH_FRONT) || (req_q == REQ_PUSH_BACK);
  assign full      = (cnt_q == FULL_CNT);
  assign front_dec = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
  assign back_sum  = SW'(front_q) + SW'(cnt_q);
  assign back_idx  = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);

  // A push that fits writes one entry and moves the count.
  assign wr_en   = cmd_i.exec_push && is_push && !full;
  assign wr_addr = (req_q == REQ_PUSH_FRONT) ? front_dec : back_idx;

  always_comb begin
    front_d = front_q;
    cnt_d   = cnt_q;
    if (wr_en) begin
      cnt_d = cnt_q + 1'b1;
      if (req_q == REQ_PUSH_FRONT) begin
        front_d = front_dec;
      end
    end
  end

  // Scan reads one entry a cycle and compares the word read the cycle before.
  assign issue_rd = cmd_i.scan_step && (scan_k_q != cnt_q);
  assign match    = rd_pend_q && (rd_data == val_q);

  bdqs_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (val_q),
    .rd_en_i   (issue_rd),
    .rd_addr_i (rd_ptr_q),
    .rd_data_o (rd_data)
  );

  // Status back to the controller.
  assign sts_o.is_query  = (req_q == REQ_QUERY);
  assign sts_o.scan_done = match || ((scan_k_q == cnt_q) && !rd_pend_q);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_data_i.req_type;
      val_q <= in_data_i.value;
    end
  end

  // Ring pointer and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      cnt_q   <= '0;
    end else begin
      front_q <= front_d;
      cnt_q   <= cnt_d;
    end
  end

  // Scan pointer, counter and hit flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q  <= '0;
      scan_k_q  <= '0;
      rd_pend_q <= 1'b0;
      found_q   <= 1'b0;
    end else if (cmd_i.scan_start) begin
      rd_ptr_q  <= front_q;
      scan_k_q  <= '0;
      rd_pend_q <= 1'b0;
      found_q   <= 1'b0;
    end else if (cmd_i.scan_step) begin
      rd_pend_q <= issue_rd;
      found_q   <= found_q || match;
      if (issue_rd) begin
        rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
        scan_k_q <= scan_k_q + 1'b1;
      end
    end
  end

  // Result register: loaded when free or taken, held while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.found    <= (req_q == REQ_QUERY) && found_q;
      out_q.count    <= 5'(cnt_d);
      out_q.is_empty <= (cnt_d == '0);
      out_q.dropped  <= is_push && full;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks on ring state and result loading.
  `BDQS_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= FULL_CNT)
  `BDQS_ASSERT_NOW(a_front_bound, clk_i, rst_ni, 1'b1, front_q <= LAST_IDX)
  `BDQS_ASSERT_NEXT(a_push_count, clk_i, rst_ni, wr_en, cnt_q == $past(cnt_q) + 1'b1)
  `BDQS_ASSERT_NOW(a_load_free, clk_i, rst_ni, cmd_i.load_out, sts_o.out_free)
  `BDQS_ASSERT_NOW(a_read_in_range, clk_i, rst_ni, issue_rd, scan_k_q < cnt_q)

endmodule

[hdl/bounded_deque_with_search_top.sv]
// =============================================================================
// Bounded deque with membership search
// Top level joining the controller and the datapath.
// =============================================================================
// Holds up to DEPTH signed 32-bit elements in a ring and answers every request
// word with one result word. A push at the front or back is applied together
// with the loading of its result, and a push into a full store is refused
// with dropped set. A query scans the stored elements in order through the
// single read port of the entry memory, one entry per cycle, and stops at the
// first hit. No input is accepted while a request is being worked on; a
// finished result waits in an output register while the next word is taken.
// Entry storage needs no clearing after reset.
// =============================================================================
module bounded_deque_with_search_top
  import bdqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  bdqs_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output bdqs_out_t out_data_o
);

  bdqs_cmd_t cmd;
  bdqs_sts_t sts;

  bdqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bdqs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
